/* src/math_language_tokenizer_core_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros used by the tokenizer checker
// ---------------------------------------------------------------------------
`ifndef MATH_LANGUAGE_TOKENIZER_CORE_MACROS_SVH
`define MATH_LANGUAGE_TOKENIZER_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define MLT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: lbl");

// next-cycle implication, disabled in reset
`define MLT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: lbl");

`endif

/* src/mlt_pkg.sv */
// ---------------------------------------------------------------------------
// mlt_pkg
// Types, token codes, character codes and scan functions of the tokenizer.
// ---------------------------------------------------------------------------
`default_nettype none

package mlt_pkg;

    localparam int POS_W   = 16;
    localparam int LEN_W   = 16;
    localparam int KIND_W  = 6;
    localparam int NUM_KW  = 11;
    localparam int KW_MAXL = 9;
    localparam int MAX_TOK = 3;
    // longest chain of re-scans of one byte: 'N' then word, ident rest, idle
    localparam int CHAIN   = 4;

    typedef logic [POS_W-1:0]  t_pos;
    typedef logic [LEN_W-1:0]  t_len;
    typedef logic [KIND_W-1:0] t_kind;

    typedef enum logic [4:0] {
        S_IDLE, S_EQ, S_EQ_SLASH, S_LT, S_GT, S_MINUS, S_LBRACE, S_LPAREN,
        S_NCOL, S_DOT, S_SLASH, S_BAR, S_QUOTE, S_DOLLAR, S_COLON, S_WORD,
        S_WORD_REST, S_QSYM, S_NUM, S_NUM_DOT, S_BAD
    } t_state;

    localparam t_kind K_INVALID = 6'd0;
    localparam t_kind K_IDENT   = 6'd1;
    localparam t_kind K_INT     = 6'd2;
    localparam t_kind K_SYM     = 6'd3;
    localparam t_kind K_QPAREN  = 6'd4;
    localparam t_kind K_DLBRACE = 6'd5;
    localparam t_kind K_DDOLLAR = 6'd6;
    localparam t_kind K_DCOLON  = 6'd7;
    localparam t_kind K_EQEQ    = 6'd8;
    localparam t_kind K_NEQ     = 6'd9;
    localparam t_kind K_EQ      = 6'd10;
    localparam t_kind K_LE      = 6'd11;
    localparam t_kind K_LARROW  = 6'd12;
    localparam t_kind K_LT      = 6'd13;
    localparam t_kind K_GE      = 6'd14;
    localparam t_kind K_GT      = 6'd15;
    localparam t_kind K_MINUS   = 6'd16;
    localparam t_kind K_LBCOL   = 6'd17;
    localparam t_kind K_LBRACE  = 6'd18;
    localparam t_kind K_LPCOL   = 6'd19;
    localparam t_kind K_LPAREN  = 6'd20;
    localparam t_kind K_NCOL    = 6'd21;
    localparam t_kind K_RANGE   = 6'd22;
    localparam t_kind K_DSLASH  = 6'd23;
    localparam t_kind K_SLASH   = 6'd24;
    localparam t_kind K_BARDOT  = 6'd25;
    localparam t_kind K_RBRACE  = 6'd26;
    localparam t_kind K_RPAREN  = 6'd27;
    localparam t_kind K_LBRACK  = 6'd28;
    localparam t_kind K_RBRACK  = 6'd29;
    localparam t_kind K_SEMI    = 6'd30;
    localparam t_kind K_COMMA   = 6'd31;
    localparam t_kind K_PLUS    = 6'd32;
    localparam t_kind K_STAR    = 6'd33;
    localparam t_kind K_PCT     = 6'd34;
    localparam t_kind K_CARET   = 6'd35;
    localparam t_kind K_BANG    = 6'd36;
    localparam t_kind K_KW0     = 6'd37;
    localparam t_kind K_REAL    = 6'd48;
    localparam t_kind K_END     = 6'd49;

    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_N      = 8'h4E;
    localparam logic [7:0] CH_UZ     = 8'h5A;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LZ     = 8'h7A;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_BAR    = 8'h7C;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    localparam logic [7:0] KW_CH [NUM_KW][KW_MAXL] = '{
        '{"l", "e", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"f", "u", "n", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"t", "h", "e", "n", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"o", "t", "h", "e", "r", "w", "i", "s", "e"},
        '{"s", "u", "m", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"p", "r", "o", "d", "u", "c", "t", 8'h00, 8'h00},
        '{"n", "i", "l", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"I", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"S", "e", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };
    localparam logic [3:0] KW_LEN [NUM_KW] = '{
        4'd3, 4'd3, 4'd2, 4'd4, 4'd4, 4'd9, 4'd3, 4'd7, 4'd3, 4'd3, 4'd3
    };

    typedef struct packed {
        t_state             st;
        t_pos               line;
        t_pos               col;
        t_pos               tline;
        t_pos               tcol;
        t_len               len;
        logic [NUM_KW-1:0]  kw;
        logic               dot;
    } t_scan;

    typedef struct packed {
        t_kind kind;
        t_pos  line;
        t_pos  col;
        t_len  len;
    } t_tok;

    typedef struct packed {
        t_scan nx;
        logic  tv;
        t_tok  tok;
        logic  again;
    } t_cell;

    // tokens produced by one item, in order
    typedef struct packed {
        logic [1:0]           cnt;
        t_tok [MAX_TOK-1:0]   tok;
    } t_burst;

    function automatic t_pos pos_inc(t_pos v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic t_len len_inc(t_len v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic t_len kw_len_ext(int i);
        return {{(LEN_W-4){1'b0}}, KW_LEN[i]};
    endfunction

    function automatic logic is_space(logic e, logic [7:0] b);
        return !e && (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR));
    endfunction

    function automatic logic is_alpha(logic e, logic [7:0] b);
        return !e && ((b >= CH_UA && b <= CH_UZ) || (b >= CH_LA && b <= CH_LZ));
    endfunction

    function automatic logic is_digit(logic e, logic [7:0] b);
        return !e && b >= CH_0 && b <= CH_9;
    endfunction

    function automatic logic is_ch(logic e, logic [7:0] b, logic [7:0] c);
        return !e && b == c;
    endfunction

    function automatic logic is_first_id(logic e, logic [7:0] b);
        return is_alpha(e, b) || is_ch(e, b, CH_UNDER);
    endfunction

    function automatic logic is_id(logic e, logic [7:0] b);
        return is_first_id(e, b) || is_digit(e, b);
    endfunction

    function automatic logic [NUM_KW-1:0] kw_update(logic [NUM_KW-1:0] m, t_len pos,
                                                    logic [7:0] b);
        logic [NUM_KW-1:0] r;
        r = m;
        for (int i = 0; i < NUM_KW; i++) begin
            if (m[i] && (!(pos < kw_len_ext(i)) || KW_CH[i][pos[3:0]] != b)) begin
                r[i] = 1'b0;
            end
        end
        return r;
    endfunction

    function automatic t_scan scan_reset();
        t_scan s;
        s.st    = S_IDLE;
        s.line  = t_pos'(1);
        s.col   = t_pos'(1);
        s.tline = t_pos'(1);
        s.tcol  = t_pos'(1);
        s.len   = '0;
        s.kw    = '1;
        s.dot   = 1'b0;
        return s;
    endfunction

    function automatic t_scan adv(t_scan s, logic [7:0] b);
        t_scan r;
        r = s;
        if (b == CH_NL) begin
            r.line = pos_inc(s.line);
            r.col  = t_pos'(1);
        end else begin
            r.col = pos_inc(s.col);
        end
        return r;
    endfunction

    function automatic t_scan take(t_scan s, logic [7:0] b);
        t_scan r;
        r = adv(s, b);
        r.len = len_inc(s.len);
        return r;
    endfunction

    function automatic t_kind single_kind(logic [7:0] b);
        t_kind k;
        unique case (b)
            CH_RBRACE: k = K_RBRACE;
            CH_RPAREN: k = K_RPAREN;
            CH_LBRACK: k = K_LBRACK;
            CH_RBRACK: k = K_RBRACK;
            CH_SEMI:   k = K_SEMI;
            CH_COMMA:  k = K_COMMA;
            CH_PLUS:   k = K_PLUS;
            CH_STAR:   k = K_STAR;
            CH_PCT:    k = K_PCT;
            CH_CARET:  k = K_CARET;
            CH_BANG:   k = K_BANG;
            default:   k = K_INVALID;
        endcase
        return k;
    endfunction

    // One scan step on one byte (or end mark). again = byte must be scanned
    // again in the new state.
    function automatic t_cell scan_cell(t_scan sc, logic e, logic [7:0] b);
        t_cell  r;
        t_scan  n;
        logic   fv;
        t_kind  fk;
        logic   ag;
        logic   hs;
        t_state hst;
        logic [7:0] hb;
        logic   clr;
        logic   hit;
        t_kind  sk;
        n   = sc;
        fv  = 1'b0;
        fk  = K_INVALID;
        ag  = 1'b0;
        hs  = 1'b0;
        hst = S_IDLE;
        hb  = CH_SLASH;
        clr = 1'b0;
        hit = 1'b0;
        sk  = K_INVALID;
        unique case (sc.st)
            S_IDLE: begin
                if (e) begin
                    n.tline = sc.line;
                    n.tcol  = sc.col;
                    n.len   = '0;
                    fv  = 1'b1;
                    fk  = K_END;
                    clr = 1'b1;
                end else if (is_space(e, b)) begin
                    n = adv(sc, b);
                end else begin
                    n.tline = sc.line;
                    n.tcol  = sc.col;
                    n.len   = '0;
                    n.dot   = 1'b0;
                    n = take(n, b);
                    sk = single_kind(b);
                    unique case (b)
                        CH_EQ:     n.st = S_EQ;
                        CH_LT:     n.st = S_LT;
                        CH_GT:     n.st = S_GT;
                        CH_MINUS:  n.st = S_MINUS;
                        CH_LBRACE: n.st = S_LBRACE;
                        CH_LPAREN: n.st = S_LPAREN;
                        CH_N:      n.st = S_NCOL;
                        CH_DOT:    n.st = S_DOT;
                        CH_SLASH:  n.st = S_SLASH;
                        CH_BAR:    n.st = S_BAR;
                        CH_QUOTE:  n.st = S_QUOTE;
                        CH_DOLLAR: n.st = S_DOLLAR;
                        CH_COLON:  n.st = S_COLON;
                        default: begin
                            if (sk != K_INVALID) begin
                                fv = 1'b1;
                                fk = sk;
                            end else if (is_alpha(e, b)) begin
                                n.kw = kw_update('1, '0, b);
                                n.st = S_WORD;
                            end else if (b == CH_UNDER) begin
                                n.st = S_WORD_REST;
                            end else if (is_digit(e, b)) begin
                                n.st = S_NUM;
                            end else begin
                                n.st = S_BAD;
                            end
                        end
                    endcase
                end
            end
            S_EQ: begin
                if (is_ch(e, b, CH_EQ)) begin
                    n = take(n, b); fv = 1'b1; fk = K_EQEQ;
                end else if (is_ch(e, b, CH_SLASH)) begin
                    n.st = S_EQ_SLASH;
                end else begin
                    fv = 1'b1; fk = K_EQ; ag = 1'b1;
                end
            end
            S_EQ_SLASH: begin
                if (is_ch(e, b, CH_EQ)) begin
                    n = take(n, CH_SLASH);
                    n = take(n, b);
                    fv = 1'b1; fk = K_NEQ;
                end else begin
                    // '=' alone, then the held slash starts its own token
                    fv = 1'b1; fk = K_EQ; ag = 1'b1;
                    hs = 1'b1; hst = S_SLASH; hb = CH_SLASH;
                end
            end
            S_LT: begin
                if (is_ch(e, b, CH_EQ)) begin
                    n = take(n, b); fv = 1'b1; fk = K_LE;
                end else if (is_ch(e, b, CH_MINUS)) begin
                    n = take(n, b); fv = 1'b1; fk = K_LARROW;
                end else begin
                    fv = 1'b1; fk = K_LT; ag = 1'b1;
                end
            end
            S_GT: begin
                fv = 1'b1;
                if (is_ch(e, b, CH_EQ)) begin
                    n = take(n, b); fk = K_GE;
                end else begin
                    fk = K_GT; ag = 1'b1;
                end
            end
            S_MINUS: begin
                if (is_digit(e, b)) begin
                    n = take(n, b); n.st = S_NUM;
                end else begin
                    fv = 1'b1; fk = K_MINUS; ag = 1'b1;
                end
            end
            S_LBRACE: begin
                fv = 1'b1;
                if (is_ch(e, b, CH_COLON)) begin
                    n = take(n, b); fk = K_LBCOL;
                end else begin
                    fk = K_LBRACE; ag = 1'b1;
                end
            end
            S_LPAREN: begin
                fv = 1'b1;
                if (is_ch(e, b, CH_COLON)) begin
                    n = take(n, b); fk = K_LPCOL;
                end else begin
                    fk = K_LPAREN; ag = 1'b1;
                end
            end
            S_NCOL: begin
                if (is_ch(e, b, CH_COLON)) begin
                    n = take(n, b); fv = 1'b1; fk = K_NCOL;
                end else begin
                    n.kw = kw_update('1, '0, CH_N);
                    n.st = S_WORD;
                    ag   = 1'b1;
                end
            end
            S_DOT: begin
                if (is_ch(e, b, CH_DOT)) begin
                    n = take(n, b); fv = 1'b1; fk = K_RANGE;
                end else begin
                    n.st = S_BAD; ag = 1'b1;
                end
            end
            S_SLASH: begin
                fv = 1'b1;
                if (is_ch(e, b, CH_SLASH)) begin
                    n = take(n, b); fk = K_DSLASH;
                end else begin
                    fk = K_SLASH; ag = 1'b1;
                end
            end
            S_BAR: begin
                if (is_ch(e, b, CH_DOT)) begin
                    n = take(n, b); fv = 1'b1; fk = K_BARDOT;
                end else begin
                    n.st = S_BAD; ag = 1'b1;
                end
            end
            S_QUOTE: begin
                if (is_ch(e, b, CH_LPAREN)) begin
                    n = take(n, b); fv = 1'b1; fk = K_QPAREN;
                end else if (is_first_id(e, b)) begin
                    n = take(n, b); n.st = S_QSYM;
                end else begin
                    n.st = S_BAD; ag = 1'b1;
                end
            end
            S_DOLLAR: begin
                if (is_ch(e, b, CH_LBRACE)) begin
                    n = take(n, b); fv = 1'b1; fk = K_DLBRACE;
                end else if (is_ch(e, b, CH_DOLLAR)) begin
                    n = take(n, b); fv = 1'b1; fk = K_DDOLLAR;
                end else begin
                    n.st = S_BAD; ag = 1'b1;
                end
            end
            S_COLON: begin
                if (is_ch(e, b, CH_COLON)) begin
                    n = take(n, b); fv = 1'b1; fk = K_DCOLON;
                end else begin
                    n.st = S_BAD; ag = 1'b1;
                end
            end
            S_WORD: begin
                if (is_alpha(e, b)) begin
                    n.kw = kw_update(sc.kw, sc.len, b);
                    n = take(n, b);
                end else begin
                    for (int i = 0; i < NUM_KW; i++) begin
                        if (!hit && sc.kw[i] && sc.len == kw_len_ext(i)) begin
                            hit = 1'b1;
                            fk  = K_KW0 + t_kind'(i);
                        end
                    end
                    // no keyword: the alpha run continues as an identifier
                    fv = hit;
                    if (!hit) begin
                        n.st = S_WORD_REST;
                    end
                    ag = 1'b1;
                end
            end
            S_WORD_REST: begin
                if (is_id(e, b)) begin
                    n = take(n, b);
                end else begin
                    fv = 1'b1; fk = K_IDENT; ag = 1'b1;
                end
            end
            S_QSYM: begin
                if (is_id(e, b)) begin
                    n = take(n, b);
                end else begin
                    fv = 1'b1; fk = K_SYM; ag = 1'b1;
                end
            end
            S_NUM: begin
                if (is_digit(e, b)) begin
                    n = take(n, b);
                end else if (is_ch(e, b, CH_DOT) && !sc.dot) begin
                    n.st = S_NUM_DOT;
                end else begin
                    fv = 1'b1; fk = sc.dot ? K_REAL : K_INT; ag = 1'b1;
                end
            end
            S_NUM_DOT: begin
                if (is_ch(e, b, CH_DOT)) begin
                    // integer, then the held dot starts a range token
                    fv = 1'b1; fk = K_INT; ag = 1'b1;
                    hs = 1'b1; hst = S_DOT; hb = CH_DOT;
                end else begin
                    n = take(n, CH_DOT);
                    n.dot = 1'b1;
                    n.st  = S_NUM;
                    ag    = 1'b1;
                end
            end
            S_BAD: begin
                if (e || is_space(e, b)) begin
                    fv = 1'b1; fk = K_INVALID; ag = 1'b1;
                end else begin
                    n = take(n, b);
                end
            end
            default: begin
                n = scan_reset();
            end
        endcase

        r.tv       = fv;
        r.tok.kind = fk;
        r.tok.line = n.tline;
        r.tok.col  = n.tcol;
        r.tok.len  = n.len;
        if (fv) begin
            n.st  = S_IDLE;
            n.dot = 1'b0;
            n.len = '0;
        end
        if (hs) begin
            n.tline = n.line;
            n.tcol  = n.col;
            n = take(n, hb);
            n.st = hst;
        end
        if (clr) begin
            n = scan_reset();
        end
        r.nx    = n;
        r.again = ag;
        return r;
    endfunction

endpackage

`default_nettype wire

/* src/mlt_step.sv */
// ---------------------------------------------------------------------------
// mlt_step
// Scanner state register and the per-item scan chain; collects the tokens.
// ---------------------------------------------------------------------------
`default_nettype none

module mlt_step (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_fire,
    input  wire logic           i_end,
    input  wire logic [7:0]     i_byte,
    output mlt_pkg::t_burst     o_burst
);
    import mlt_pkg::*;

    t_scan  r_scan;
    t_scan  n_scan;
    t_scan  sc;
    t_cell  scan_res;
    t_burst burst;
    logic   act;

    // a byte may be re-scanned in a new state a few times in one item
    always_comb begin
        sc       = r_scan;
        act      = 1'b1;
        burst    = '0;
        scan_res = '0;
        for (int k = 0; k < CHAIN; k++) begin
            if (act) begin
                scan_res = scan_cell(sc, i_end, i_byte);
                sc       = scan_res.nx;
                if (scan_res.tv && burst.cnt < 2'(MAX_TOK)) begin
                    burst.tok[burst.cnt] = scan_res.tok;
                    burst.cnt = burst.cnt + 2'd1;
                end
                act = scan_res.again;
            end
        end
        n_scan = i_fire ? sc : r_scan;
    end

    assign o_burst = burst;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan <= scan_reset();
        end else begin
            r_scan <= n_scan;
        end
    end

endmodule

`default_nettype wire

/* src/mlt_outq.sv */
// ---------------------------------------------------------------------------
// mlt_outq
// Result register: holds the tokens of one item and hands them out in order.
// ---------------------------------------------------------------------------
`default_nettype none

module mlt_outq (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_load,
    input  mlt_pkg::t_burst     i_burst,
    output logic                o_can_load,
    output logic                o_valid,
    input  wire logic           i_ready,
    output mlt_pkg::t_tok       o_tok,
    output logic                o_last
);
    import mlt_pkg::*;

    t_tok       r_tok [MAX_TOK];
    logic [1:0] r_cnt;
    logic [1:0] r_idx;
    logic [1:0] n_cnt;
    logic [1:0] n_idx;
    logic [1:0] idx_p1;
    logic [1:0] sel;

    assign idx_p1     = r_idx + 2'd1;
    assign o_valid    = (r_idx != r_cnt);
    assign o_can_load = !o_valid || (idx_p1 == r_cnt && i_ready);
    assign sel        = (r_idx == 2'(MAX_TOK)) ? 2'd0 : r_idx;
    assign o_tok      = r_tok[sel];
    assign o_last     = (idx_p1 == r_cnt);

    always_comb begin
        n_cnt = r_cnt;
        n_idx = r_idx;
        if (i_load) begin
            n_cnt = i_burst.cnt;
            n_idx = 2'd0;
        end else if (o_valid && i_ready) begin
            n_idx = idx_p1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_idx <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            r_idx <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int k = 0; k < MAX_TOK; k++) begin
                r_tok[k] <= i_burst.tok[k];
            end
        end
    end

endmodule

`default_nettype wire

/* src/math_language_tokenizer_core.sv */
// ---------------------------------------------------------------------------
// math_language_tokenizer_core
// Streaming tokenizer: one byte or end mark in, zero to three tokens out.
// ---------------------------------------------------------------------------
//  channel | handshake                  | payload
//  --------+----------------------------+--------------------------------------
//  in      | i_in_valid / o_in_ready    | i_kind, i_char_code
//  out     | o_out_valid / i_out_ready  | o_token_kind, o_start_line,
//          |                            | o_start_column, o_token_length,
//          |                            | o_last_of_run
//
//  One item per cycle is taken while each item gives at most one token and
//  the consumer is ready. An item is scanned from the input register; its
//  tokens load into the output register and are offered one per cycle while
//  the consumer is ready, so an item with several tokens stalls the next item.
//  The output register frees while its last token transfers.
//  Synchronous active-low reset returns to line 1, column 1, idle.
// ---------------------------------------------------------------------------
`default_nettype none

module math_language_tokenizer_core (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire logic                   i_kind,
    input  wire logic [7:0]             i_char_code,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output mlt_pkg::t_kind              o_token_kind,
    output mlt_pkg::t_pos               o_start_line,
    output mlt_pkg::t_pos               o_start_column,
    output mlt_pkg::t_len               o_token_length,
    output logic                        o_last_of_run
);
    import mlt_pkg::*;

    logic       r_in_v;
    logic       r_kind;
    logic [7:0] r_char;
    logic       fire;
    logic       can_load;
    t_burst     burst;
    t_tok       tok;

    assign fire       = r_in_v && can_load;
    assign o_in_ready = !r_in_v || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_v <= 1'b1;
        end else if (fire) begin
            r_in_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_kind <= i_kind;
            r_char <= i_char_code;
        end
    end

    mlt_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_end   (r_kind),
        .i_byte  (r_char),
        .o_burst (burst)
    );

    mlt_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (fire),
        .i_burst    (burst),
        .o_can_load (can_load),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_tok      (tok),
        .o_last     (o_last_of_run)
    );

    assign o_token_kind   = tok.kind;
    assign o_start_line   = tok.line;
    assign o_start_column = tok.col;
    assign o_token_length = tok.len;

endmodule

`default_nettype wire

/* src/mlt_checker.sv */
// ---------------------------------------------------------------------------
// mlt_checker
// Port-level checks on the tokenizer, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "math_language_tokenizer_core_macros.svh"

module mlt_checker (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire logic           o_in_ready,
    input  wire logic           i_kind,
    input  wire logic [7:0]     i_char_code,
    input  wire logic           o_out_valid,
    input  wire logic           i_out_ready,
    input  mlt_pkg::t_kind      o_token_kind,
    input  mlt_pkg::t_pos       o_start_line,
    input  mlt_pkg::t_pos       o_start_column,
    input  mlt_pkg::t_len       o_token_length,
    input  wire logic           o_last_of_run
);
    import mlt_pkg::*;

    logic [KIND_W+2*POS_W+LEN_W:0] out_bits;
    logic [8:0]                    in_bits;

    assign out_bits = {o_token_kind, o_start_line, o_start_column, o_token_length,
                       o_last_of_run};
    assign in_bits  = {i_kind, i_char_code};

    `MLT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)
    `MLT_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready, $stable(out_bits))
    `MLT_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, i_in_valid && !o_in_ready, i_in_valid && $stable(in_bits))
    `MLT_ASSERT_NOW(a_stall_has_output, i_clk, i_rst_n, !o_in_ready, o_out_valid)
    `MLT_ASSERT_NOW(a_end_closes_run, i_clk, i_rst_n, o_out_valid && o_token_kind == K_END, o_last_of_run && o_token_length == '0)

endmodule

bind math_language_tokenizer_core mlt_checker u_mlt_checker (.*);

`default_nettype wire

/* verif/testbench.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Tokenizer testbench
// Streams directed and random source bytes through the tokenizer, predicts
// every token with an independent scanner model and checks them in order.
// ---------------------------------------------------------------------------
`default_nettype none

typedef struct packed {
    logic [5:0]  kind;
    logic [15:0] line;
    logic [15:0] col;
    logic [15:0] len;
    logic        last;
} t_tb_tok;

class token_scoreboard;
    t_tb_tok pending[$];
    int   errors;

    // scanner state
    mlt_pkg::t_state st;
    logic [15:0] line, col, tline, tcol, len;
    logic [10:0] kwm;
    logic        dot;
    logic [7:0]  held;
    int          held_n;
    int          burst;

    string kw_text[11] = '{"let", "fun", "if", "then", "else", "otherwise",
                           "sum", "product", "nil", "Int", "Set"};

    function void clear();
        st = mlt_pkg::S_IDLE;
        line = 1; col = 1; tline = 1; tcol = 1; len = 0;
        kwm = '1; dot = 0; held_n = 0;
    endfunction

    function void report(string what, logic [15:0] got, logic [15:0] want);
        errors++;
        $display("mismatch %s: got %0d want %0d", what, got, want);
    endfunction

    static function bit sp(int s);
        return s == 32 || (s >= 9 && s <= 13);
    endfunction
    static function bit alpha(int s);
        return (s >= 65 && s <= 90) || (s >= 97 && s <= 122);
    endfunction
    static function bit digit(int s);
        return s >= 48 && s <= 57;
    endfunction
    static function bit idc(int s);
        return alpha(s) || digit(s) || s == 95;
    endfunction

    function logic [10:0] kw_narrow(logic [10:0] m, int p, int s);
        for (int i = 0; i < 11; i++)
            if (m[i] && (p >= kw_text[i].len() || kw_text[i][p] != s)) m[i] = 0;
        return m;
    endfunction

    function void step_pos(int s);
        if (s == 10) begin
            if (line != 16'hFFFF) line++;
            col = 1;
        end else if (col != 16'hFFFF) col++;
    endfunction

    function void grab(int s);
        if (len != 16'hFFFF) len++;
        step_pos(s);
    endfunction

    function void emit(int k, logic [15:0] l, logic [15:0] c, logic [15:0] n);
        t_tb_tok t;
        t.kind = 6'(k); t.line = l; t.col = c; t.len = n; t.last = 0;
        if (burst < 3) begin
            pending.insert(pending.size(), t);
            burst++;
        end
    endfunction

    function void done(int k);
        emit(k, tline, tcol, len);
        st = mlt_pkg::S_IDLE; dot = 0; len = 0;
    endfunction

    function void choose(int s, int want, int hit, int miss);
        if (s == want) begin grab(s); done(hit); end
        else begin done(miss); scan(s); end
    endfunction

    function void replay();
        int n;
        logic [7:0] b;
        n = held_n; b = held; held_n = 0;
        if (n > 0) scan(b);
    endfunction

    // s = 256 marks end of input
    function void scan(int s);
        case (st)
            mlt_pkg::S_IDLE: begin
                if (s == 256) begin
                    emit(mlt_pkg::K_END, line, col, 0);
                    clear();
                    return;
                end
                if (sp(s)) begin step_pos(s); return; end
                tline = line; tcol = col; len = 0; dot = 0;
                grab(s);
                case (s)
                    "=": st = mlt_pkg::S_EQ;
                    "<": st = mlt_pkg::S_LT;
                    ">": st = mlt_pkg::S_GT;
                    "-": st = mlt_pkg::S_MINUS;
                    "{": st = mlt_pkg::S_LBRACE;
                    "(": st = mlt_pkg::S_LPAREN;
                    "N": st = mlt_pkg::S_NCOL;
                    ".": st = mlt_pkg::S_DOT;
                    "/": st = mlt_pkg::S_SLASH;
                    "|": st = mlt_pkg::S_BAR;
                    "'": st = mlt_pkg::S_QUOTE;
                    "$": st = mlt_pkg::S_DOLLAR;
                    ":": st = mlt_pkg::S_COLON;
                    "}": done(mlt_pkg::K_RBRACE);
                    ")": done(mlt_pkg::K_RPAREN);
                    "[": done(mlt_pkg::K_LBRACK);
                    "]": done(mlt_pkg::K_RBRACK);
                    ";": done(mlt_pkg::K_SEMI);
                    ",": done(mlt_pkg::K_COMMA);
                    "+": done(mlt_pkg::K_PLUS);
                    "*": done(mlt_pkg::K_STAR);
                    "%": done(mlt_pkg::K_PCT);
                    "^": done(mlt_pkg::K_CARET);
                    "!": done(mlt_pkg::K_BANG);
                    default: begin
                        if (alpha(s)) begin
                            kwm = kw_narrow('1, 0, s); st = mlt_pkg::S_WORD;
                        end else if (s == "_") st = mlt_pkg::S_WORD_REST;
                        else if (digit(s)) st = mlt_pkg::S_NUM;
                        else st = mlt_pkg::S_BAD;
                    end
                endcase
            end
            mlt_pkg::S_EQ: begin
                if (s == "=") begin grab(s); done(mlt_pkg::K_EQEQ); end
                else if (s == "/") begin held = s; held_n = 1; st = mlt_pkg::S_EQ_SLASH; end
                else begin done(mlt_pkg::K_EQ); scan(s); end
            end
            mlt_pkg::S_EQ_SLASH: begin
                if (s == "=") begin
                    held_n = 0; grab("/"); grab(s); done(mlt_pkg::K_NEQ);
                end else begin
                    done(mlt_pkg::K_EQ); replay(); scan(s);
                end
            end
            mlt_pkg::S_LT: begin
                if (s == "=") begin grab(s); done(mlt_pkg::K_LE); end
                else if (s == "-") begin grab(s); done(mlt_pkg::K_LARROW); end
                else begin done(mlt_pkg::K_LT); scan(s); end
            end
            mlt_pkg::S_GT: choose(s, "=", mlt_pkg::K_GE, mlt_pkg::K_GT);
            mlt_pkg::S_MINUS: begin
                if (digit(s)) begin grab(s); st = mlt_pkg::S_NUM; end
                else begin done(mlt_pkg::K_MINUS); scan(s); end
            end
            mlt_pkg::S_LBRACE: choose(s, ":", mlt_pkg::K_LBCOL, mlt_pkg::K_LBRACE);
            mlt_pkg::S_LPAREN: choose(s, ":", mlt_pkg::K_LPCOL, mlt_pkg::K_LPAREN);
            mlt_pkg::S_NCOL: begin
                if (s == ":") begin grab(s); done(mlt_pkg::K_NCOL); end
                else begin kwm = kw_narrow('1, 0, "N"); st = mlt_pkg::S_WORD; scan(s); end
            end
            mlt_pkg::S_DOT: begin
                if (s == ".") begin grab(s); done(mlt_pkg::K_RANGE); end
                else begin st = mlt_pkg::S_BAD; scan(s); end
            end
            mlt_pkg::S_SLASH: choose(s, "/", mlt_pkg::K_DSLASH, mlt_pkg::K_SLASH);
            mlt_pkg::S_BAR: begin
                if (s == ".") begin grab(s); done(mlt_pkg::K_BARDOT); end
                else begin st = mlt_pkg::S_BAD; scan(s); end
            end
            mlt_pkg::S_QUOTE: begin
                if (s == "(") begin grab(s); done(mlt_pkg::K_QPAREN); end
                else if (alpha(s) || s == "_") begin grab(s); st = mlt_pkg::S_QSYM; end
                else begin st = mlt_pkg::S_BAD; scan(s); end
            end
            mlt_pkg::S_DOLLAR: begin
                if (s == "{") begin grab(s); done(mlt_pkg::K_DLBRACE); end
                else if (s == "$") begin grab(s); done(mlt_pkg::K_DDOLLAR); end
                else begin st = mlt_pkg::S_BAD; scan(s); end
            end
            mlt_pkg::S_COLON: begin
                if (s == ":") begin grab(s); done(mlt_pkg::K_DCOLON); end
                else begin st = mlt_pkg::S_BAD; scan(s); end
            end
            mlt_pkg::S_WORD: begin
                if (alpha(s)) begin
                    kwm = kw_narrow(kwm, len, s);
                    grab(s);
                    return;
                end
                for (int i = 0; i < 11; i++)
                    if (kwm[i] && kw_text[i].len() == len) begin
                        done(mlt_pkg::K_KW0 + i);
                        scan(s);
                        return;
                    end
                st = mlt_pkg::S_WORD_REST;
                scan(s);
            end
            mlt_pkg::S_WORD_REST: begin
                if (s != 256 && idc(s)) grab(s);
                else begin done(mlt_pkg::K_IDENT); scan(s); end
            end
            mlt_pkg::S_QSYM: begin
                if (s != 256 && idc(s)) grab(s);
                else begin done(mlt_pkg::K_SYM); scan(s); end
            end
            mlt_pkg::S_NUM: begin
                if (digit(s)) grab(s);
                else if (s == "." && !dot) begin held = s; held_n = 1; st = mlt_pkg::S_NUM_DOT; end
                else begin done(dot ? mlt_pkg::K_REAL : mlt_pkg::K_INT); scan(s); end
            end
            mlt_pkg::S_NUM_DOT: begin
                if (s == ".") begin
                    done(mlt_pkg::K_INT); replay(); scan(s);
                end else begin
                    held_n = 0; grab("."); dot = 1; st = mlt_pkg::S_NUM; scan(s);
                end
            end
            default: begin
                if (s == 256 || sp(s)) begin done(mlt_pkg::K_INVALID); scan(s); end
                else grab(s);
            end
        endcase
    endfunction

    function void note_input(bit e, logic [7:0] b);
        int first;
        first = pending.size();
        burst = 0;
        scan(e ? 256 : b);
        if (pending.size() > first) pending[pending.size() - 1].last = 1;
    endfunction

    function void check_token(t_tb_tok got);
        t_tb_tok w;
        if (pending.size() == 0) begin
            errors++;
            $display("token with none expected: kind %0d", got.kind);
            return;
        end
        w = pending.pop_front();
        if (got.kind != w.kind) report("kind", 16'(got.kind), 16'(w.kind));
        if (got.line != w.line) report("line", got.line, w.line);
        if (got.col != w.col) report("column", got.col, w.col);
        if (got.len != w.len) report("length", got.len, w.len);
        if (got.last != w.last) report("last", 16'(got.last), 16'(w.last));
    endfunction
endclass

module testbench;
    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_in_valid = 0;
    logic        i_kind = 0;
    logic [7:0]  i_char_code = 0;
    logic        i_out_ready = 0;
    logic        o_in_ready, o_out_valid, o_last_of_run;
    mlt_pkg::t_kind o_token_kind;
    mlt_pkg::t_pos  o_start_line, o_start_column;
    mlt_pkg::t_len  o_token_length;

    token_scoreboard tokens;
    int out_stall_max = 3;

    math_language_tokenizer_core dut (.*);

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    // valid stays high after a transfer; stop_input, or a gap in the next call, drops it
    task automatic send(bit e, logic [7:0] b);
        int g;
        g = gap_len();
        if (g > 0) begin
            i_in_valid <= 0;
            i_kind <= 1'($urandom_range(0, 1));
            i_char_code <= 8'($urandom_range(0, 255));
            repeat (g) @(posedge i_clk);
        end
        i_in_valid <= 1; i_kind <= e; i_char_code <= b;
        do @(posedge i_clk); while (!o_in_ready);
        tokens.note_input(e, b);
    endtask

    task automatic stop_input();
        i_in_valid <= 0;
    endtask

    task automatic drain();
        do @(posedge i_clk); while (tokens.pending.size() != 0);
    endtask

    task automatic send_text(string t);
        for (int i = 0; i < t.len(); i++) send(0, t[i]);
    endtask

    // consumer with random stalls
    always @(posedge i_clk) begin
        t_tb_tok got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.kind = o_token_kind; got.line = o_start_line; got.col = o_start_column;
            got.len = o_token_length; got.last = o_last_of_run;
            tokens.check_token(got);
        end
        if (!i_rst_n) i_out_ready <= 0;
        else if ($urandom_range(0, 99) < 70) i_out_ready <= 1;
        else i_out_ready <= ($urandom_range(0, out_stall_max) == 0);
    end

    string pieces[] = '{"let ", "fun ", "if ", "then ", "else ", "otherwise ", "sum ",
        "product ", "nil ", "Int ", "Set ", "let_x ", "x1 ", "_a9 ", "'sym ", "'( ",
        "${", "$$", "::", "==", "=/=", "=/+", "= ", "<=", "<-", "< ", ">=", "> ",
        "-7 ", "- ", "{:", "{ ", "(:", "( ", "N:", "Nx ", "..", "//", "/ ", "|.",
        "}", ")", "[", "]", ";", ",", "+", "*", "%", "^", "!", "1..2 ", "3.5 ",
        "1.", "4.2.1 ", "12345 ", ": ", "$ ", "| ", "' ", ". ", "\n", "\t", "otherwis ",
        "Setx ", "ifelse "};

    initial begin
        int n;
        string p;
        tokens = new();
        tokens.clear();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        // directed
        send_text("let_x=/=1..2");
        send(1, 8'h00);
        send_text("=/+");
        send(1, 8'h00);
        send_text("'a 1. x");
        send(0, 8'h80);
        send(0, 8'hFF);
        send(0, 8'h00);
        send(1, 8'h00);
        send_text("|");
        send(1, 8'h00);
        stop_input();
        // let everything drain before going on
        drain();
        // random: mostly well-formed pieces, some noise
        n = 0;
        while (n < 290) begin
            if ($urandom_range(0, 9) < 7) begin
                p = pieces[$urandom_range(0, pieces.size() - 1)];
                send_text(p);
                n += p.len();
            end else if ($urandom_range(0, 9) == 0) begin
                send(1, 8'($urandom_range(0, 255)));
                n++;
            end else begin
                send(0, 8'($urandom_range(0, 255)));
                n++;
            end
            if (n > 150 && n < 160) out_stall_max = 8;
        end
        send(1, 8'h00);
        stop_input();
        drain();
        repeat (20) @(posedge i_clk);
        if (tokens.errors == 0 && tokens.pending.size() == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end
endmodule

`default_nettype wire

/* sim.f */
+incdir+src
src/mlt_pkg.sv
src/mlt_step.sv
src/mlt_outq.sv
src/math_language_tokenizer_core.sv
src/mlt_checker.sv
verif/testbench.sv
